// ===== design/m4ct_pkg.sv =====
package m4ct_pkg;

	// fixed-point format of every matrix element and vector component
	localparam int FRAC_BITS = 16;
	localparam int DATA_W    = 32;
	localparam int PROD_W    = 2 * DATA_W;
	// four exact products summed need two guard bits
	localparam int ACC_W     = PROD_W + 2;
	localparam int DIM       = 4;
	localparam int IDX_W     = $clog2(DIM);

	localparam logic [DATA_W-1:0] ONE_FX = DATA_W'(1) << FRAC_BITS;

	// command codes
	localparam logic [2:0] CMD_WR_CUR  = 3'd0;
	localparam logic [2:0] CMD_WR_OP   = 3'd1;
	localparam logic [2:0] CMD_IDENT   = 3'd2;
	localparam logic [2:0] CMD_COMPOSE = 3'd3;
	localparam logic [2:0] CMD_XFORM   = 3'd4;

	// controller -> datapath
	typedef struct packed {
		logic             wr_cur;    // write one element of current matrix
		logic             wr_op;     // write one element of operand matrix
		logic             ident;     // reload current matrix with identity
		logic             start;     // latch vector of a new transaction
		logic             src_vec;   // multiplier B side: vector, else operand column
		logic             mul_en;    // issue products for term k
		logic [IDX_W-1:0] k;         // term index
		logic             acc_en;    // accumulate registered products
		logic             acc_first; // first term: load instead of add
		logic             fin_en;    // round, saturate and store the four sums
		logic [IDX_W-1:0] col;       // result column during compose
		logic             commit;    // copy composed matrix into current
	} m4ct_ctl_t;

	// datapath -> controller
	typedef struct packed {
		logic out_free;              // output register can take a result now
	} m4ct_stat_t;

endpackage

// ===== design/m4ct_ctrl.sv =====
module m4ct_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [2:0]           cmd,
	input  m4ct_pkg::m4ct_stat_t stat,
	output m4ct_pkg::m4ct_ctl_t  ctl
);

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_RUN    = 2'd1;
	localparam logic [1:0] ST_COMMIT = 2'd2;

	// step 0..3 multiply, 1..4 accumulate, STEP_FIN round and store
	localparam logic [2:0] STEP_LAST_MUL = 3'd3;
	localparam logic [2:0] STEP_LAST_ACC = 3'd4;
	localparam logic [2:0] STEP_FIN      = 3'd5;

	logic [1:0]                     state_q;
	logic [2:0]                     step_q;
	logic [m4ct_pkg::IDX_W-1:0]     col_q;
	logic                           xf_q;
	logic                           accept;

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;

	always_comb begin
		ctl           = '0;
		ctl.k         = step_q[m4ct_pkg::IDX_W-1:0];
		ctl.col       = col_q;
		ctl.src_vec   = xf_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					unique case (cmd)
						m4ct_pkg::CMD_WR_CUR:  ctl.wr_cur = 1'b1;
						m4ct_pkg::CMD_WR_OP:   ctl.wr_op  = 1'b1;
						m4ct_pkg::CMD_IDENT:   ctl.ident  = 1'b1;
						m4ct_pkg::CMD_XFORM:   ctl.start  = 1'b1;
						default: ;
					endcase
				end
			end
			ST_RUN: begin
				ctl.mul_en    = (step_q <= STEP_LAST_MUL);
				ctl.acc_en    = (step_q != 3'd0) && (step_q <= STEP_LAST_ACC);
				ctl.acc_first = (step_q == 3'd1);
				ctl.fin_en    = (step_q == STEP_FIN) && (!xf_q || stat.out_free);
			end
			ST_COMMIT: ctl.commit = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
			col_q   <= '0;
			xf_q    <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					step_q <= '0;
					col_q  <= '0;
					if (accept && (cmd == m4ct_pkg::CMD_COMPOSE || cmd == m4ct_pkg::CMD_XFORM)) begin
						state_q <= ST_RUN;
						xf_q    <= (cmd == m4ct_pkg::CMD_XFORM);
					end
				end
				ST_RUN: begin
					if (step_q != STEP_FIN) begin
						step_q <= step_q + 3'd1;
					end else if (ctl.fin_en) begin
						step_q <= '0;
						if (xf_q) begin
							state_q <= ST_IDLE;
						end else if (col_q == m4ct_pkg::IDX_W'(m4ct_pkg::DIM - 1)) begin
							state_q <= ST_COMMIT;
						end else begin
							col_q <= col_q + 1'b1;
						end
					end
				end
				ST_COMMIT: state_q <= ST_IDLE;
				default:   state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// ===== design/m4ct_dp.sv =====
module m4ct_dp (
	input  logic                        clk,
	input  logic                        arst_n,
	input  m4ct_pkg::m4ct_ctl_t         ctl,
	output m4ct_pkg::m4ct_stat_t        stat,
	input  logic [1:0]                  row_index,
	input  logic [1:0]                  col_index,
	input  logic signed [31:0]          elem_value,
	input  logic signed [31:0]          in_x,
	input  logic signed [31:0]          in_y,
	input  logic signed [31:0]          in_z,
	input  logic signed [31:0]          in_w,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic signed [31:0]          out_x,
	output logic signed [31:0]          out_y,
	output logic signed [31:0]          out_z,
	output logic signed [31:0]          out_w,
	output logic                        sat_flag
);

	localparam int DW  = m4ct_pkg::DATA_W;
	localparam int PW  = m4ct_pkg::PROD_W;
	localparam int AW  = m4ct_pkg::ACC_W;
	localparam int N   = m4ct_pkg::DIM;
	localparam logic signed [AW-1:0] HALF = AW'(1) << (m4ct_pkg::FRAC_BITS - 1);

	// one row of the current matrix per MAC lane
	logic signed [DW-1:0] cur_q [N][N];
	logic signed [DW-1:0] op_q  [N][N];
	logic signed [DW-1:0] nxt_q [N][N];
	logic signed [DW-1:0] vec_q [N];
	logic signed [PW-1:0] prod_s1 [N];
	logic signed [AW-1:0] acc_q [N];
	logic signed [DW-1:0] res_q [N];
	logic                 sat_q;
	logic                 out_valid_q;

	logic signed [DW-1:0] b_sel;
	logic signed [AW-1:0] rnd  [N];
	logic signed [DW-1:0] fin_val [N];
	logic        [N-1:0]  fin_sat;

	assign b_sel = ctl.src_vec ? vec_q[ctl.k] : op_q[ctl.k][ctl.col];

	// round half up, then clamp to 32 bits
	always_comb begin
		for (int i = 0; i < N; i++) begin
			rnd[i] = (acc_q[i] + HALF) >>> m4ct_pkg::FRAC_BITS;
			if (!rnd[i][AW-1] && (|rnd[i][AW-2:DW-1])) begin
				fin_val[i] = {1'b0, {(DW-1){1'b1}}};
				fin_sat[i] = 1'b1;
			end else if (rnd[i][AW-1] && !(&rnd[i][AW-2:DW-1])) begin
				fin_val[i] = {1'b1, {(DW-1){1'b0}}};
				fin_sat[i] = 1'b1;
			end else begin
				fin_val[i] = rnd[i][DW-1:0];
				fin_sat[i] = 1'b0;
			end
		end
	end

	// matrix state: reset value is the identity
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < N; i++) begin
				for (int j = 0; j < N; j++) begin
					cur_q[i][j] <= (i == j) ? m4ct_pkg::ONE_FX : '0;
					op_q[i][j]  <= (i == j) ? m4ct_pkg::ONE_FX : '0;
				end
			end
		end else begin
			if (ctl.wr_cur) begin
				cur_q[row_index][col_index] <= elem_value;
			end
			if (ctl.wr_op) begin
				op_q[row_index][col_index] <= elem_value;
			end
			if (ctl.ident) begin
				for (int i = 0; i < N; i++) begin
					for (int j = 0; j < N; j++) begin
						cur_q[i][j] <= (i == j) ? m4ct_pkg::ONE_FX : '0;
					end
				end
			end
			if (ctl.commit) begin
				cur_q <= nxt_q;
			end
		end
	end

	// MAC lanes and result buffers
	always_ff @(posedge clk) begin
		if (ctl.start) begin
			vec_q[0] <= in_x;
			vec_q[1] <= in_y;
			vec_q[2] <= in_z;
			vec_q[3] <= in_w;
		end
		for (int i = 0; i < N; i++) begin
			if (ctl.mul_en) begin
				prod_s1[i] <= cur_q[i][ctl.k] * b_sel;
			end
			if (ctl.acc_en) begin
				acc_q[i] <= (ctl.acc_first ? '0 : acc_q[i]) + AW'(prod_s1[i]);
			end
			if (ctl.fin_en && !ctl.src_vec) begin
				nxt_q[i][ctl.col] <= fin_val[i];
			end
			if (ctl.fin_en && ctl.src_vec) begin
				res_q[i] <= fin_val[i];
			end
		end
		if (ctl.fin_en && ctl.src_vec) begin
			sat_q <= |fin_sat;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.fin_en && ctl.src_vec) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign stat.out_free = !out_valid_q || out_ready;
	assign out_valid     = out_valid_q;
	assign out_x         = res_q[0];
	assign out_y         = res_q[1];
	assign out_z         = res_q[2];
	assign out_w         = res_q[3];
	assign sat_flag      = sat_q;

endmodule

// ===== design/matrix4_compose_and_transform.sv =====
// Channel  | handshake            | payload
// ---------+----------------------+------------------------------------------------
// input    | in_valid / in_ready  | cmd, row_index, col_index, elem_value, in_x..in_w
// output   | out_valid/ out_ready | out_x, out_y, out_z, out_w, sat_flag
//
// Element writes and identity reload are stored at the accept; the sequencer stays idle.
// Transform: after the accept cycle the four MAC lanes multiply the terms, drain the
// last product and round; the next vector waits for that rounding, and the result
// shows the cycle after rounding. Compose: the lanes run that pass once per column,
// then commit copies the new matrix in before the next transaction is accepted.
// Reset loads both matrices with the identity; a held result stalls the rounding
// step of the next transform, and in_ready stays low until that result is taken.
module matrix4_compose_and_transform (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [2:0]         cmd,
	input  logic [1:0]         row_index,
	input  logic [1:0]         col_index,
	input  logic signed [31:0] elem_value,
	input  logic signed [31:0] in_x,
	input  logic signed [31:0] in_y,
	input  logic signed [31:0] in_z,
	input  logic signed [31:0] in_w,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] out_x,
	output logic signed [31:0] out_y,
	output logic signed [31:0] out_z,
	output logic signed [31:0] out_w,
	output logic               sat_flag
);

	// command bundle from the sequencer, status back from the lanes
	m4ct_pkg::m4ct_ctl_t  ctl;
	m4ct_pkg::m4ct_stat_t stat;

	// sequencer: decodes each transaction, steps term / column counters
	m4ct_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.cmd      (cmd),
		.stat     (stat),
		.ctl      (ctl)
	);

	// datapath: matrices, four MAC lanes (one per row), round/saturate, output reg
	m4ct_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (ctl),
		.stat       (stat),
		.row_index  (row_index),
		.col_index  (col_index),
		.elem_value (elem_value),
		.in_x       (in_x),
		.in_y       (in_y),
		.in_z       (in_z),
		.in_w       (in_w),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_x      (out_x),
		.out_y      (out_y),
		.out_z      (out_z),
		.out_w      (out_w),
		.sat_flag   (sat_flag)
	);

endmodule
